/* hw/rtl/millisecond_calendar_clock_top_assert.svh */
// Assertion macros used by the calendar clock core (mcc_core).
`ifndef MILLISECOND_CALENDAR_CLOCK_TOP_ASSERT_SVH
`define MILLISECOND_CALENDAR_CLOCK_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define MCC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check a consequence in the cycle after an antecedent.
`define MCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mcc_pkg.sv */
package mcc_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_SET  = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    // Calendar time fields
    typedef struct packed {
        logic [9:0]  ms;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } cal_time_t;

    // One input item as held in the input register
    typedef struct packed {
        logic [1:0] action;
        cal_time_t  new_time;
    } item_t;

    // One result item
    typedef struct packed {
        cal_time_t   now;
        logic [31:0] tick_total;
        logic        set_accepted;
    } result_t;

    localparam logic [9:0]  MS_MAX    = 10'd999;
    localparam logic [5:0]  SEC_MAX   = 6'd59;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [4:0]  DAY_MIN   = 5'd1;
    localparam logic [3:0]  MONTH_MIN = 4'd1;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [15:0] YEAR_MIN  = 16'd2000;
    localparam logic [15:0] YEAR_MAX  = 16'd2099;

    localparam cal_time_t RESET_TIME = '{
        ms:    10'd0,
        sec:   6'd0,
        min:   6'd0,
        hour:  5'd0,
        day:   5'd1,
        month: 4'd1,
        year:  16'd2000
    };

    // Month length; February gains a day when the year's two low bits are zero
    function automatic logic [4:0] month_days(input logic [3:0] month,
                                              input logic [15:0] year);
        logic [4:0] d;
        begin
            unique case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
                4'd2:                                      d = 5'd28;
                default:                                   d = 5'd0;
            endcase
            if (month == MONTH_FEB && year[1:0] == 2'b00)
            begin
                d = d + 5'd1;
            end
            return d;
        end
    endfunction

endpackage

/* hw/rtl/mcc_in_stage.sv */
module mcc_in_stage
    import mcc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;

    // Free the slot when empty or when the held item moves on this cycle
    assign in_ready        = !item_valid_reg || take;
    assign item_valid_next = (in_valid && in_ready) || (item_valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // Capture the payload on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/mcc_core.sv */
module mcc_core
    import mcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  item_t   item,
    output result_t res_next
);

    `include "millisecond_calendar_clock_top_assert.svh"

    cal_time_t   time_reg;
    cal_time_t   time_next;
    cal_time_t   adv_time;
    logic [31:0] tick_reg;
    logic [31:0] tick_next;
    logic        set_ok;
    logic        accepted;
    logic [4:0]  cur_days;
    logic [4:0]  new_days;
    action_t     act;

    assign act      = action_t'(item.action);
    assign cur_days = month_days(time_reg.month, time_reg.year);
    assign new_days = month_days(item.new_time.month, item.new_time.year);

    // Advance by one millisecond, rippling carries upward
    always_comb
    begin
        adv_time = time_reg;
        if (time_reg.ms < MS_MAX)
        begin
            adv_time.ms = time_reg.ms + 10'd1;
        end
        else
        begin
            adv_time.ms = 10'd0;
            if (time_reg.sec < SEC_MAX)
            begin
                adv_time.sec = time_reg.sec + 6'd1;
            end
            else
            begin
                adv_time.sec = 6'd0;
                if (time_reg.min < MIN_MAX)
                begin
                    adv_time.min = time_reg.min + 6'd1;
                end
                else
                begin
                    adv_time.min = 6'd0;
                    if (time_reg.hour < HOUR_MAX)
                    begin
                        adv_time.hour = time_reg.hour + 5'd1;
                    end
                    else
                    begin
                        adv_time.hour = 5'd0;
                        if (time_reg.day < cur_days)
                        begin
                            adv_time.day = time_reg.day + 5'd1;
                        end
                        else
                        begin
                            adv_time.day = DAY_MIN;
                            if (time_reg.month < MONTH_MAX)
                            begin
                                adv_time.month = time_reg.month + 4'd1;
                            end
                            else
                            begin
                                adv_time.month = MONTH_MIN;
                                adv_time.year  = time_reg.year + 16'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Validate a requested time
    assign set_ok = (item.new_time.ms <= MS_MAX)
                 && (item.new_time.sec <= SEC_MAX)
                 && (item.new_time.min <= MIN_MAX)
                 && (item.new_time.hour <= HOUR_MAX)
                 && (item.new_time.month >= MONTH_MIN)
                 && (item.new_time.month <= MONTH_MAX)
                 && (item.new_time.year >= YEAR_MIN)
                 && (item.new_time.year <= YEAR_MAX)
                 && (item.new_time.day >= DAY_MIN)
                 && (item.new_time.day <= new_days);

    // Select the state after this item; reads and the spare code hold
    always_comb
    begin
        time_next = time_reg;
        tick_next = tick_reg;
        accepted  = 1'b0;
        if (take)
        begin
            unique case (act)
                ACT_TICK:
                begin
                    time_next = adv_time;
                    tick_next = tick_reg + 32'd1;
                end
                ACT_SET:
                begin
                    if (set_ok)
                    begin
                        time_next = item.new_time;
                        accepted  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= RESET_TIME;
            tick_reg <= 32'd0;
        end
        else
        begin
            time_reg <= time_next;
            tick_reg <= tick_next;
        end
    end

    assign res_next.now          = time_next;
    assign res_next.tick_total   = tick_next;
    assign res_next.set_accepted = accepted;

    `MCC_ASSERT_ALWAYS(a_month_range, (time_reg.month >= MONTH_MIN) && (time_reg.month <= MONTH_MAX), "month out of range")
    `MCC_ASSERT_ALWAYS(a_day_range, (time_reg.day >= DAY_MIN) && (time_reg.day <= cur_days), "day outside month")
    `MCC_ASSERT_ALWAYS(a_ms_range, time_reg.ms <= MS_MAX, "millisecond out of range")
    `MCC_ASSERT_NEXT(a_tick_only, !(take && act == ACT_TICK), $stable(tick_reg), "tick count moved without a tick")
    `MCC_ASSERT_NEXT(a_idle_hold, !take, $stable(time_reg), "time moved without a transfer")

endmodule

/* hw/rtl/mcc_out_stage.sv */
module mcc_out_stage
    import mcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  result_t res_next,
    output logic    take,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;

    // Move an item forward when the result register is empty or being drained
    assign take           = item_valid && (!out_valid_reg || out_ready);
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

/* hw/rtl/millisecond_calendar_clock_top.sv */
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid, in_ready  | action, new_millisecond .. new_year
// output   | out_valid, out_ready| millisecond .. year, tick_total, set_accepted
//
// One item per cycle sustained while out_ready stays high; a result passes the input register,
// then the result register, after its input transfer, and is then offered on the output.
// The time and tick state updates as the item leaves the input register.
// Reset gives 2000-01-01 00:00:00.000 with a zero tick count.
// A stalled output holds its result while one more item waits at the input.
module millisecond_calendar_clock_top
    import mcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [9:0]  new_millisecond,
    input  logic [5:0]  new_second,
    input  logic [5:0]  new_minute,
    input  logic [4:0]  new_hour,
    input  logic [4:0]  new_day,
    input  logic [3:0]  new_month,
    input  logic [15:0] new_year,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  millisecond,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [15:0] year,
    output logic [31:0] tick_total,
    output logic        set_accepted
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t res_next;
    result_t res;

    // Gather input ports into one item
    assign in_item.action         = action;
    assign in_item.new_time.ms    = new_millisecond;
    assign in_item.new_time.sec   = new_second;
    assign in_item.new_time.min   = new_minute;
    assign in_item.new_time.hour  = new_hour;
    assign in_item.new_time.day   = new_day;
    assign in_item.new_time.month = new_month;
    assign in_item.new_time.year  = new_year;

    mcc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mcc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .res_next (res_next)
    );

    mcc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .res_next   (res_next),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res        (res)
    );

    // Spread the result onto the output ports
    assign millisecond  = res.now.ms;
    assign second       = res.now.sec;
    assign minute       = res.now.min;
    assign hour         = res.now.hour;
    assign day          = res.now.day;
    assign month        = res.now.month;
    assign year         = res.now.year;
    assign tick_total   = res.tick_total;
    assign set_accepted = res.set_accepted;

endmodule

/* test/millisecond_calendar_clock_checker.sv */
module millisecond_calendar_clock_checker
    import mcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [9:0]  new_millisecond,
    input  logic [5:0]  new_second,
    input  logic [5:0]  new_minute,
    input  logic [4:0]  new_hour,
    input  logic [4:0]  new_day,
    input  logic [3:0]  new_month,
    input  logic [15:0] new_year,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [9:0]  millisecond,
    input  logic [5:0]  second,
    input  logic [5:0]  minute,
    input  logic [4:0]  hour,
    input  logic [4:0]  day,
    input  logic [3:0]  month,
    input  logic [15:0] year,
    input  logic [31:0] tick_total,
    input  logic        set_accepted,
    output int          errors,
    output int          outstanding
);

    // Predicted calendar, tick count and the readings still due
    cal_time_t   cal_now;
    logic [31:0] tick_count;
    result_t     due_readings[$];

    // Print one line for a mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("checker: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Length of a month, with the leap day when the year's two low bits are clear
    function automatic logic [4:0] last_day_of(input logic [3:0] mon, input logic [15:0] yr);
        logic [4:0] days;
        days = 5'd31;
        if (mon < MONTH_MIN || mon > MONTH_MAX)
        begin
            days = 5'd0;
        end
        else if (mon == MONTH_FEB)
        begin
            days = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end
        else if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11)
        begin
            days = 5'd30;
        end
        return days;
    endfunction

    function automatic logic time_is_valid(input cal_time_t t);
        return t.ms <= MS_MAX && t.sec <= SEC_MAX && t.min <= MIN_MAX
            && t.hour <= HOUR_MAX && t.month >= MONTH_MIN && t.month <= MONTH_MAX
            && t.year >= YEAR_MIN && t.year <= YEAR_MAX
            && t.day >= DAY_MIN && t.day <= last_day_of(t.month, t.year);
    endfunction

    // Advance one millisecond and ripple the carries upward
    function automatic void advance_one_ms();
        tick_count = tick_count + 32'd1;
        if (cal_now.ms < MS_MAX)
        begin
            cal_now.ms++;
            return;
        end
        cal_now.ms = '0;
        if (cal_now.sec < SEC_MAX)
        begin
            cal_now.sec++;
            return;
        end
        cal_now.sec = '0;
        if (cal_now.min < MIN_MAX)
        begin
            cal_now.min++;
            return;
        end
        cal_now.min = '0;
        if (cal_now.hour < HOUR_MAX)
        begin
            cal_now.hour++;
            return;
        end
        cal_now.hour = '0;
        if (cal_now.day < last_day_of(cal_now.month, cal_now.year))
        begin
            cal_now.day++;
            return;
        end
        cal_now.day = DAY_MIN;
        if (cal_now.month < MONTH_MAX)
        begin
            cal_now.month++;
            return;
        end
        cal_now.month = MONTH_MIN;
        cal_now.year = cal_now.year + 16'd1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t   want;
        cal_time_t req;
        if (!rst_n)
        begin
            cal_now     = RESET_TIME;
            tick_count  = '0;
            errors      = 0;
            due_readings.delete();
            outstanding <= 0;
        end
        else
        begin
            // Compare a result transfer with the oldest reading due
            if (out_valid && out_ready)
            begin
                if (due_readings.size() == 0)
                begin
                    report_mismatch("result with no expectation waiting");
                end
                else
                begin
                    want = due_readings.pop_front();
                    check_field("millisecond", 32'(millisecond), 32'(want.now.ms));
                    check_field("second", 32'(second), 32'(want.now.sec));
                    check_field("minute", 32'(minute), 32'(want.now.min));
                    check_field("hour", 32'(hour), 32'(want.now.hour));
                    check_field("day", 32'(day), 32'(want.now.day));
                    check_field("month", 32'(month), 32'(want.now.month));
                    check_field("year", 32'(year), 32'(want.now.year));
                    check_field("tick_total", tick_total, want.tick_total);
                    check_field("set_accepted", 32'(set_accepted), 32'(want.set_accepted));
                end
            end

            // Apply an input transfer to the predicted calendar
            if (in_valid && in_ready)
            begin
                want.set_accepted = 1'b0;
                if (action == ACT_TICK)
                begin
                    advance_one_ms();
                end
                else if (action == ACT_SET)
                begin
                    req.ms    = new_millisecond;
                    req.sec   = new_second;
                    req.min   = new_minute;
                    req.hour  = new_hour;
                    req.day   = new_day;
                    req.month = new_month;
                    req.year  = new_year;
                    if (time_is_valid(req))
                    begin
                        cal_now = req;
                        want.set_accepted = 1'b1;
                    end
                end
                want.now        = cal_now;
                want.tick_total = tick_count;
                due_readings.push_back(want);
            end
            outstanding <= due_readings.size();
        end
    end

endmodule

/* test/millisecond_calendar_clock_top_tb.sv */
module millisecond_calendar_clock_top_tb;
    import mcc_pkg::*;

    // The unused action code, which the block treats as a read
    localparam logic [1:0] ACT_SPARE    = 2'd3;
    localparam int         ITEM_COUNT   = 1650;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = 8;
    localparam cal_time_t  BLANK_TIME   = '0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [9:0]  new_millisecond;
    logic [5:0]  new_second;
    logic [5:0]  new_minute;
    logic [4:0]  new_hour;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;
    logic        out_valid;
    logic        out_ready;
    logic [9:0]  millisecond;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [31:0] tick_total;
    logic        set_accepted;

    int errors;
    int outstanding;
    int cycles = 0;
    bit quiet_input = 1'b0;
    int stall_left = 0;
    int mode_left = 0;
    bit stalls_on = 1'b1;

    millisecond_calendar_clock_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .new_millisecond(new_millisecond), .new_second(new_second),
        .new_minute(new_minute), .new_hour(new_hour), .new_day(new_day),
        .new_month(new_month), .new_year(new_year),
        .out_valid(out_valid), .out_ready(out_ready),
        .millisecond(millisecond), .second(second), .minute(minute), .hour(hour),
        .day(day), .month(month), .year(year), .tick_total(tick_total),
        .set_accepted(set_accepted)
    );

    millisecond_calendar_clock_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .new_millisecond(new_millisecond), .new_second(new_second),
        .new_minute(new_minute), .new_hour(new_hour), .new_day(new_day),
        .new_month(new_month), .new_year(new_year),
        .out_valid(out_valid), .out_ready(out_ready),
        .millisecond(millisecond), .second(second), .minute(minute), .hour(hour),
        .day(day), .month(month), .year(year), .tick_total(tick_total),
        .set_accepted(set_accepted),
        .errors(errors), .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("millisecond_calendar_clock_top_tb: done, errors");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Stall the result side, with clean stretches in between
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stalls_on = ($urandom_range(0, 3) != 0);
            mode_left = $urandom_range(50, 300);
        end
        else
        begin
            mode_left--;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_idle_len() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [4:0] month_end(input logic [3:0] mon, input logic [15:0] yr);
        if (mon == MONTH_FEB)
        begin
            return (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end
        if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11)
        begin
            return 5'd30;
        end
        return 5'd31;
    endfunction

    function automatic cal_time_t at_time(input int ms, input int sec, input int min,
                                          input int hr, input int dy, input int mon,
                                          input int yr);
        cal_time_t t;
        t.ms    = 10'(ms);
        t.sec   = 6'(sec);
        t.min   = 6'(min);
        t.hour  = 5'(hr);
        t.day   = 5'(dy);
        t.month = 4'(mon);
        t.year  = 16'(yr);
        return t;
    endfunction

    // Any bit pattern at all
    function automatic cal_time_t noise_time();
        cal_time_t t;
        t.ms    = 10'($urandom);
        t.sec   = 6'($urandom);
        t.min   = 6'($urandom);
        t.hour  = 5'($urandom);
        t.day   = 5'($urandom);
        t.month = 4'($urandom);
        t.year  = 16'($urandom);
        return t;
    endfunction

    // A real date, leaning toward the end of each field so ticks carry far
    function automatic cal_time_t pick_valid_time();
        cal_time_t t;
        t.year  = YEAR_MIN + 16'($urandom_range(0, 99));
        t.month = ($urandom_range(0, 2) == 0) ? MONTH_MAX : 4'($urandom_range(1, 12));
        t.day   = ($urandom_range(0, 1) == 0) ? month_end(t.month, t.year)
                : 5'($urandom_range(1, 32'(month_end(t.month, t.year))));
        t.hour  = ($urandom_range(0, 4) < 3) ? HOUR_MAX : 5'($urandom_range(0, 23));
        t.min   = ($urandom_range(0, 4) < 3) ? MIN_MAX : 6'($urandom_range(0, 59));
        t.sec   = ($urandom_range(0, 4) < 3) ? SEC_MAX : 6'($urandom_range(0, 59));
        t.ms    = ($urandom_range(0, 4) < 3) ? MS_MAX - 10'($urandom_range(0, 3))
                : 10'($urandom_range(0, 999));
        return t;
    endfunction

    // A real date with exactly one field pushed out of range
    function automatic cal_time_t broken_time();
        cal_time_t t;
        t = pick_valid_time();
        case ($urandom_range(0, 6))
            0: t.ms = 10'($urandom_range(1000, 1023));
            1: t.sec = 6'($urandom_range(60, 63));
            2: t.min = 6'($urandom_range(60, 63));
            3: t.hour = 5'($urandom_range(24, 31));
            4: t.day = ($urandom_range(0, 1) == 0) ? 5'd0 : month_end(t.month, t.year) + 5'd1;
            5: t.month = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
            default: t.year = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1999))
                            : 16'($urandom_range(2100, 65535));
        endcase
        return t;
    endfunction

    // Present one item, after an optional gap, and hold it until the transfer
    task automatic issue_item(input logic [1:0] act, input cal_time_t t);
        int gap;
        gap = 0;
        if (!quiet_input && $urandom_range(0, 99) < 35)
        begin
            gap = pick_idle_len();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= act;
        new_millisecond <= t.ms;
        new_second      <= t.sec;
        new_minute      <= t.min;
        new_hour        <= t.hour;
        new_day         <= t.day;
        new_month       <= t.month;
        new_year        <= t.year;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int pick;
        int burst;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        action          <= ACT_TICK;
        new_millisecond <= '0;
        new_second      <= '0;
        new_minute      <= '0;
        new_hour        <= '0;
        new_day         <= '0;
        new_month       <= '0;
        new_year        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset state, spare code, field extremes, leap days, rollovers
        issue_item(ACT_READ, BLANK_TIME);
        issue_item(ACT_TICK, BLANK_TIME);
        issue_item(ACT_SPARE, at_time(1023, 63, 63, 31, 31, 15, 65535));
        issue_item(ACT_SET, at_time(999, 59, 59, 23, 31, 12, 2099));
        issue_item(ACT_TICK, BLANK_TIME);
        issue_item(ACT_SET, at_time(0, 0, 0, 0, 1, 1, 2000));
        issue_item(ACT_SET, at_time(1000, 0, 0, 0, 1, 1, 2000));
        issue_item(ACT_SET, at_time(0, 60, 0, 0, 1, 1, 2000));
        issue_item(ACT_SET, at_time(0, 0, 60, 0, 1, 1, 2000));
        issue_item(ACT_SET, at_time(0, 0, 0, 24, 1, 1, 2000));
        issue_item(ACT_SET, at_time(0, 0, 0, 0, 0, 1, 2000));
        issue_item(ACT_SET, at_time(0, 0, 0, 0, 1, 0, 2000));
        issue_item(ACT_SET, at_time(0, 0, 0, 0, 1, 13, 2000));
        issue_item(ACT_SET, at_time(0, 0, 0, 0, 1, 1, 1999));
        issue_item(ACT_SET, at_time(0, 0, 0, 0, 1, 1, 2100));
        issue_item(ACT_SET, at_time(0, 0, 0, 0, 29, 2, 2001));
        issue_item(ACT_SET, at_time(500, 30, 30, 12, 29, 2, 2000));
        issue_item(ACT_SET, at_time(999, 59, 59, 23, 28, 2, 2096));
        issue_item(ACT_TICK, BLANK_TIME);
        issue_item(ACT_SET, at_time(999, 59, 59, 23, 28, 2, 2097));
        issue_item(ACT_TICK, BLANK_TIME);
        issue_item(ACT_SET, at_time(999, 59, 59, 23, 30, 4, 2050));
        issue_item(ACT_TICK, BLANK_TIME);
        issue_item(ACT_SET, at_time(1023, 63, 63, 31, 31, 15, 65535));
        issue_item(ACT_READ, BLANK_TIME);

        // Random: mostly a valid set followed by ticks, the rest noise and bad sets
        sent = 0;
        while (sent < ITEM_COUNT)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                quiet_input = ~quiet_input;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                issue_item(ACT_SET, pick_valid_time());
                burst = $urandom_range(2, 8);
                for (int k = 0; k < burst; k++)
                begin
                    issue_item(($urandom_range(0, 9) == 0) ? ACT_READ : ACT_TICK, noise_time());
                end
                sent += burst + 1;
            end
            else
            begin
                if (pick < 60)
                begin
                    issue_item(ACT_SET, broken_time());
                end
                else if (pick < 70)
                begin
                    issue_item(ACT_SET, noise_time());
                end
                else if (pick < 80)
                begin
                    issue_item(ACT_READ, noise_time());
                end
                else if (pick < 85)
                begin
                    issue_item(ACT_SPARE, noise_time());
                end
                else
                begin
                    issue_item(ACT_TICK, noise_time());
                end
                sent++;
            end
        end

        // Drain every reading still due, then let the pipeline settle
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("millisecond_calendar_clock_top_tb: done, clean");
        end
        else
        begin
            $display("millisecond_calendar_clock_top_tb: done, errors");
        end
        $finish;
    end

endmodule
